/* sv/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Shared types, codes and lookup functions for the scan driver blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

   // Request kinds carried on the input channel's tuser.
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_NUMBER = 2'd1,
      OP_LEDS   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned STORE_SLOTS = 9;     // slots 0..8 hold bytes, slot 9 is blank
   localparam int unsigned LED_SLOT   = 8;
   localparam int unsigned NUM_MAX    = 9999;
   localparam logic [7:0]  LED_KEEP   = 8'h35;
   localparam logic [12:0] RECIP_TEN  = 13'd6554;  // round(2^16 / 10)

   // Key codes reported on the scan slots that carry a switch.
   localparam logic [2:0] KEY_NONE = 3'd0;
   localparam logic [2:0] KEY_1    = 3'd1;
   localparam logic [2:0] KEY_2    = 3'd2;
   localparam logic [2:0] KEY_3    = 3'd3;
   localparam logic [2:0] KEY_4    = 3'd4;

   // One scan job handed from the front to the back.
   typedef struct packed {
      logic [7:0]        seg_byte;
      logic [SLOT_W-1:0] channel;
      logic [2:0]        key_code;
   } scan_job_type;

   // Segment pattern of one decimal digit.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'hED;
         4'd1:    pat = 8'h21;
         4'd2:    pat = 8'h8F;
         4'd3:    pat = 8'hAB;
         4'd4:    pat = 8'h63;
         4'd5:    pat = 8'hEA;
         4'd6:    pat = 8'hEE;
         4'd7:    pat = 8'hA1;
         4'd8:    pat = 8'hEF;
         4'd9:    pat = 8'hEB;
         default: pat = 8'h80;
      endcase
      return pat;
   endfunction

   // Key code for a slot when the switch reads pressed.
   function automatic logic [2:0] key_for_slot(input logic [SLOT_W-1:0] slot,
                                                input logic pressed);
      logic [2:0] code;
      code = KEY_NONE;
      if (pressed) begin
         unique case (slot)
            4'd0:    code = KEY_1;
            4'd7:    code = KEY_2;
            4'd8:    code = KEY_3;
            4'd9:    code = KEY_4;
            default: code = KEY_NONE;
         endcase
      end
      return code;
   endfunction

endpackage

`default_nettype wire

/* sv/ssd_queue.sv */
// ----------------------------------------------------------------------------
// Scan job queue
// Two-entry queue that decouples the request front from the serial back.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ssd_pkg::scan_job_type push_job,
   output logic                 full,
   input  wire                  pop,
   output ssd_pkg::scan_job_type pop_job,
   output logic                 empty
);

   ssd_pkg::scan_job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* sv/ssd_front.sv */
// ----------------------------------------------------------------------------
// Scan driver front
// Accepts request beats, keeps the slot bytes, converts numbers to digit
// patterns one digit per cycle and turns each scan tick into a scan job.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_front #(
   parameter int unsigned SCAN_SLOTS = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [23:0]           req_tdata,
   input  wire  [1:0]            req_tuser,
   output logic                  job_push,
   output ssd_pkg::scan_job_type job,
   input  wire                   job_full
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CONV = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  slot_ff [ssd_pkg::STORE_SLOTS];
   logic [3:0]  scan_idx_ff, scan_idx_in;
   logic [13:0] rem_ff, rem_in;
   logic [1:0]  digit_ff, digit_in;
   logic        bank_ff, bank_in;

   logic [15:0] number;
   logic        bank;
   logic [3:0]  leds;
   logic        key_low;
   logic        accept;
   ssd_pkg::op_type op;

   logic [26:0] prod;
   logic [9:0]  quot;
   logic [13:0] tens;
   logic [3:0]  digit_val;
   logic [7:0]  digit_pat;
   logic [3:0]  digit_slot;
   logic [4:0]  scan_next;
   logic [7:0]  scan_byte;
   logic [7:0]  led_byte;

   // Unpack the request beat.
   assign number  = req_tdata[15:0];
   assign bank    = req_tdata[16];
   assign leds    = req_tdata[20:17];
   assign key_low = req_tdata[21];
   assign op      = ssd_pkg::op_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE) && !job_full;
   assign accept     = req_tvalid && req_tready;

   // One decimal digit per cycle through a reciprocal multiply.
   assign prod       = 27'(rem_ff) * 27'(ssd_pkg::RECIP_TEN);
   assign quot       = prod[25:16];
   assign tens       = 14'({quot, 3'b000}) + 14'({quot, 1'b0});
   assign digit_val  = 4'(rem_ff - tens);
   assign digit_slot = {1'b0, bank_ff, digit_ff};
   // Leading zeros blank: a zero remainder above the lowest digit means nothing is left.
   assign digit_pat  = ((digit_ff != 2'd0) && (rem_ff == 14'd0)) ? 8'h00
                                                                 : ssd_pkg::seg_pattern(digit_val);

   // Byte shown on the current slot; slot 9 and anything above is blank.
   assign scan_byte = (scan_idx_ff < 4'(ssd_pkg::STORE_SLOTS))
                      ? slot_ff[scan_idx_ff] : 8'h00;
   assign scan_next = 5'(scan_idx_ff) + 5'd1;

   // LED bits land on slot 8 bits 7, 6, 3 and 1.
   assign led_byte = (slot_ff[ssd_pkg::LED_SLOT] & ssd_pkg::LED_KEEP)
                   | {leds[0], leds[1], 2'b00, leds[2], 1'b0, leds[3], 1'b0};

   assign job_push     = accept && (op == ssd_pkg::OP_TICK);
   assign job.seg_byte = scan_byte;
   assign job.channel  = scan_idx_ff;
   assign job.key_code = ssd_pkg::key_for_slot(scan_idx_ff, key_low);

   // Control: classify the beat and run the digit conversion.
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      rem_in      = rem_ff;
      digit_in    = digit_ff;
      bank_in     = bank_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op == ssd_pkg::OP_TICK)) begin
               scan_idx_in = (scan_next >= 5'(SCAN_SLOTS)) ? 4'd0 : scan_next[3:0];
            end
            if (accept && (op == ssd_pkg::OP_NUMBER)
                && (number <= 16'(ssd_pkg::NUM_MAX))) begin
               state_in = ST_CONV;
               rem_in   = number[13:0];
               digit_in = 2'd0;
               bank_in  = bank;
            end
         end
         ST_CONV: begin
            rem_in   = 14'(quot);
            digit_in = digit_ff + 2'd1;
            if (digit_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_idx_ff <= 4'd0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      digit_ff <= digit_in;
      bank_ff  <= bank_in;
   end

   // Slot byte store: digit writes during conversion, LED writes when idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(ssd_pkg::STORE_SLOTS); i++) begin
            slot_ff[i] <= 8'h00;
         end
      end else if (state_ff == ST_CONV) begin
         slot_ff[digit_slot] <= digit_pat;
      end else if (accept && (op == ssd_pkg::OP_LEDS)) begin
         slot_ff[ssd_pkg::LED_SLOT] <= led_byte;
      end
   end

endmodule

`default_nettype wire

/* sv/ssd_back.sv */
// ----------------------------------------------------------------------------
// Scan driver back
// Takes scan jobs from the queue and shifts each byte out MSB first as
// eight result beats from a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  ssd_pkg::scan_job_type job,
   input  wire                   job_empty,
   output logic                  job_pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);

   logic                     busy_ff, busy_in;
   logic [7:0]               shift_ff, shift_in;
   logic [2:0]               bit_cnt_ff, bit_cnt_in;
   logic [ssd_pkg::SLOT_W-1:0] chan_ff, chan_in;
   logic [2:0]               key_ff, key_in;
   logic                     beat_done;
   logic                     final_beat;

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (bit_cnt_ff == 3'd7);
   assign rsp_tdata  = {key_ff, chan_ff, shift_ff[7]};
   assign beat_done  = busy_ff && rsp_tready;
   assign final_beat = beat_done && (bit_cnt_ff == 3'd7);
   assign job_pop    = (!busy_ff || final_beat) && !job_empty;

   // Load a new job when idle or on the eighth beat, otherwise shift on each beat.
   always_comb begin
      busy_in    = busy_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      chan_in    = chan_ff;
      key_in     = key_ff;
      if (job_pop) begin
         busy_in    = 1'b1;
         shift_in   = job.seg_byte;
         bit_cnt_in = 3'd0;
         chan_in    = job.channel;
         key_in     = job.key_code;
      end else if (final_beat) begin
         busy_in = 1'b0;
      end else if (beat_done) begin
         shift_in   = {shift_ff[6:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= 3'd0;
      end else begin
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      chan_ff  <= chan_in;
      key_ff   <= key_in;
   end

endmodule

`default_nettype wire

/* sv/seven_segment_scan_driver.sv */
// ----------------------------------------------------------------------------
// Seven-segment scan driver
// Multiplexed display driver: digit and LED writes, serial scan output.
// ----------------------------------------------------------------------------
// A tick beat accepted with the back stage idle is written into the queue, then loaded
// into the back stage registers, which raise rsp_tvalid together with its first bit.
// Throughput: eight result beats per tick, one per cycle while rsp_tready is high,
// with ticks back to back; the serial shift register in the back stage sets that rate.
// A number write holds the request side while its four digits are converted.
// Reset: all slots blank, scan index zero, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver #(
   parameter int unsigned SCAN_SLOTS = 10
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // number[15:0], bank[16], leds[20:17], key_low[21], zero
   input  wire  [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // serial_bit[0], channel[4:1], key_code[7:5]
   output logic        rsp_tlast
);

   ssd_pkg::scan_job_type push_job;
   ssd_pkg::scan_job_type pop_job;
   logic                  job_push;
   logic                  job_full;
   logic                  job_pop;
   logic                  job_empty;

   // Front: request handling and slot store.
   ssd_front #(
      .SCAN_SLOTS (SCAN_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_push   (job_push),
      .job        (push_job),
      .job_full   (job_full)
   );

   // Queue between front and back.
   ssd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .empty    (job_empty)
   );

   // Back: serial shift-out of each scan job.
   ssd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (pop_job),
      .job_empty  (job_empty),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment scan driver testbench
// Sends digit writes, LED writes and scan ticks to the driver and checks every
// serial result beat against a model of the slot store and scan position kept
// here. A short table of directed requests opens the run, random traffic with
// idle bursts on both sides follows, and the last stretch runs without idling.
// ----------------------------------------------------------------------------

module testbench;

   localparam int unsigned NUM_SLOTS   = 10;
   localparam int unsigned RANDOM_REQS = 296;
   localparam int unsigned SETTLE_CYC  = 24;

   // Segment patterns of the decimal digits 0 to 9.
   localparam logic [7:0] DIGIT_SEGS [10] = '{
      8'hED, 8'h21, 8'h8F, 8'hAB, 8'h63, 8'hEA, 8'hEE, 8'hA1, 8'hEF, 8'hEB
   };

   // One request, with an optional typed expectation for a scan tick.
   typedef struct packed {
      ssd_pkg::op_type op;
      logic [15:0] number;
      logic        bank;
      logic [3:0]  leds;
      logic        key;
      logic        typed;
      logic [7:0]  seg;
      logic [3:0]  chan;
      logic [2:0]  code;
   } request_row_type;

   // One serial bit leaving the driver.
   typedef struct packed {
      logic       serial;
      logic [3:0] chan;
      logic [2:0] code;
      logic       last;
   } scan_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // number[15:0], bank[16], leds[20:17], key_low[21], zero
   logic [1:0]  req_tuser  = ssd_pkg::OP_NONE;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // serial_bit[0], channel[4:1], key_code[7:5]
   logic        rsp_tlast;

   // Local copy of the display state.
   logic [7:0]      seg_store [NUM_SLOTS];
   logic [3:0]      scan_pos;
   scan_beat_type   scan_beats [$];
   request_row_type directed_rows [$];

   bit calm = 1'b0;
   int mismatches = 0;
   int beats_seen = 0;
   int n_ticks = 0, n_numbers = 0, n_rejected = 0, n_leds = 0, n_ignored = 0, n_keys = 0;

   seven_segment_scan_driver #(.SCAN_SLOTS(NUM_SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Guard against a hung run.
   initial begin
      #1_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   // Apply one accepted request to the local display state. A scan tick
   // queues its eight beats unless the caller supplies typed ones.
   task automatic advance_display(input request_row_type row, input bit record);
      logic [7:0]    digs [4];
      logic [15:0]   v;
      logic [7:0]    b;
      logic [2:0]    code;
      int            base;
      scan_beat_type beat;
      case (row.op)
         ssd_pkg::OP_NUMBER: begin
            n_numbers++;
            if (row.number <= 16'd9999) begin
               v = row.number;
               for (int k = 0; k < 4; k++) begin
                  digs[k] = DIGIT_SEGS[v % 10];
                  v = v / 10;
               end
               // Leading zeros are blanked; the lowest digit always shows.
               if (row.number < 10) digs[1] = 8'h00;
               if (row.number < 100) digs[2] = 8'h00;
               if (row.number < 1000) digs[3] = 8'h00;
               base = row.bank ? 4 : 0;
               for (int k = 0; k < 4; k++) seg_store[base + k] = digs[k];
            end else begin
               n_rejected++;
            end
         end
         ssd_pkg::OP_LEDS: begin
            n_leds++;
            b = seg_store[8] & 8'h35;
            if (row.leds[0]) b[7] = 1'b1;
            if (row.leds[1]) b[6] = 1'b1;
            if (row.leds[2]) b[3] = 1'b1;
            if (row.leds[3]) b[1] = 1'b1;
            seg_store[8] = b;
         end
         ssd_pkg::OP_TICK: begin
            n_ticks++;
            b = (scan_pos < NUM_SLOTS && scan_pos != 4'd9) ? seg_store[scan_pos] : 8'h00;
            code = ssd_pkg::KEY_NONE;
            if (row.key) begin
               case (scan_pos)
                  4'd0: code = ssd_pkg::KEY_1;
                  4'd7: code = ssd_pkg::KEY_2;
                  4'd8: code = ssd_pkg::KEY_3;
                  4'd9: code = ssd_pkg::KEY_4;
                  default: code = ssd_pkg::KEY_NONE;
               endcase
            end
            if (code != ssd_pkg::KEY_NONE) n_keys++;
            if (record) begin
               for (int k = 0; k < 8; k++) begin
                  beat.serial = b[7 - k];
                  beat.chan   = scan_pos;
                  beat.code   = code;
                  beat.last   = (k == 7);
                  scan_beats.push_back(beat);
               end
            end
            scan_pos = (scan_pos + 1 >= NUM_SLOTS) ? 4'd0 : scan_pos + 4'd1;
         end
         default: n_ignored++;
      endcase
   endtask

   // Present one request and hold it until the driver takes the beat.
   task automatic send_request(input request_row_type row);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= {2'b00, row.key, row.leds, row.bank, row.number};
      do @(posedge clock); while (!req_tready);
   endtask

   // Result side: check each beat and stall in random bursts.
   initial begin : result_side
      int            stall_left;
      scan_beat_type want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (scan_beats.size() == 0) begin
               flag_error($sformatf("unexpected beat data %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = scan_beats.pop_front();
               if (rsp_tdata[0] !== want.serial || rsp_tdata[4:1] !== want.chan ||
                   rsp_tdata[7:5] !== want.code || rsp_tlast !== want.last) begin
                  flag_error($sformatf(
                     "bit/ch/key/last expected %b/%0d/%0d/%b got %b/%0d/%0d/%b",
                     want.serial, want.chan, want.code, want.last,
                     rsp_tdata[0], rsp_tdata[4:1], rsp_tdata[7:5], rsp_tlast));
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Request side: reset, directed table, random traffic, then drain.
   initial begin : request_side
      request_row_type row;
      scan_beat_type   beat;
      int              pick;
      for (int s = 0; s < NUM_SLOTS; s++) seg_store[s] = 8'h00;
      scan_pos = 4'd0;

      // Directed table: op, number, bank, leds, key, typed, seg, channel, key code.
      // First tick after reset: slot 0 is blank, the switch gives key 1.
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b1, 8'h00, 4'd0, ssd_pkg::KEY_1});
      // Value zero, then the top extreme, then numbers outside the range.
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'd0,     1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'd9999,  1'b1, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'hFFFF,  1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'd10000, 1'b1, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'h8000,  1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'h7FFF,  1'b1, 4'hF, 1'b1,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      // All LEDs on, and the unused operation with every field high.
      directed_rows.push_back('{ssd_pkg::OP_LEDS,   16'hFFFF,  1'b1, 4'hF, 1'b1,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NONE,   16'hFFFF,  1'b1, 4'hF, 1'b1,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      // Walk every slot once; leading digits of zero are blank.
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b0,
                                1'b1, 8'h00, 4'd1, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b1, 8'h00, 4'd2, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b1, 8'hEB, 4'd7, ssd_pkg::KEY_2});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b1, 8'hCA, 4'd8, ssd_pkg::KEY_3});
      // Slot nine is always blank.
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b1, 8'h00, 4'd9, ssd_pkg::KEY_4});
      // LED update keeps the other bits of slot eight, then fresh numbers.
      directed_rows.push_back('{ssd_pkg::OP_LEDS,   16'd0,     1'b0, 4'h5, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'd7,     1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_NUMBER, 16'd4321,  1'b1, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b0,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});
      directed_rows.push_back('{ssd_pkg::OP_TICK,   16'd0,     1'b0, 4'h0, 1'b1,
                                1'b0, 8'h00, 4'd0, ssd_pkg::KEY_NONE});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row);
         if (row.op == ssd_pkg::OP_TICK && row.typed) begin
            for (int k = 0; k < 8; k++) begin
               beat.serial = row.seg[7 - k];
               beat.chan   = row.chan;
               beat.code   = row.code;
               beat.last   = (k == 7);
               scan_beats.push_back(beat);
            end
            advance_display(row, 1'b0);
         end else begin
            advance_display(row, 1'b1);
         end
      end

      // Random part: mostly ticks and in-range numbers of every length.
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 2) begin
            // Let the result side run dry once before carrying on.
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (scan_beats.size() != 0) @(posedge clock);
         end
         if (i == RANDOM_REQS - 60) calm = 1'b1;
         row = '0;
         pick = $urandom_range(0, 99);
         row.op = (pick < 55) ? ssd_pkg::OP_TICK : (pick < 80) ? ssd_pkg::OP_NUMBER :
                  (pick < 95) ? ssd_pkg::OP_LEDS : ssd_pkg::OP_NONE;
         case ($urandom_range(0, 9))
            0: row.number = $urandom_range(0, 9);
            1: row.number = $urandom_range(10, 99);
            2: row.number = $urandom_range(100, 999);
            3, 4: row.number = $urandom_range(1000, 9999);
            5: row.number = $urandom_range(0, 1) ? 16'd9999 : 16'd0;
            6: row.number = $urandom_range(10000, 32767);
            7: row.number = $urandom_range(0, 65535);
            8: row.number = $urandom_range(32768, 65535);
            default: row.number = $urandom_range(0, 9999);
         endcase
         row.bank = $urandom_range(0, 1);
         row.leds = $urandom_range(0, 15);
         row.key  = $urandom_range(0, 1);
         send_request(row);
         advance_display(row, 1'b1);
      end
      req_tvalid <= 1'b0;

      // Drain, then give the driver time to show any stray beat.
      while (scan_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      $display("summary: %0d ticks, %0d number writes (%0d out of range), %0d LED writes,",
               n_ticks, n_numbers, n_rejected, n_leds);
      $display("summary: %0d ignored requests, %0d keyed ticks, %0d beats, %0d mismatches",
               n_ignored, n_keys, beats_seen, mismatches);
      if (mismatches == 0 && scan_beats.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
